FILE: design/csvd_pkg.sv
// Shared types and constants for the CSV record decoder.
package csvd_pkg;

    localparam int CSVD_FIFO_DEPTH = 4;

    localparam logic [7:0] QUOTE_BYTE     = 8'h22;
    localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;
    localparam logic [7:0] X_BYTE         = 8'h78;
    localparam logic [7:0] DELIM_RESET    = 8'd44;

    localparam logic [1:0] KIND_DATA       = 2'd0;
    localparam logic [1:0] KIND_FIELD_END  = 2'd1;
    localparam logic [1:0] KIND_RECORD_END = 2'd2;
    localparam logic [1:0] KIND_ERROR      = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } t_result;

    // Up to three results caused by one input byte; count is never zero in the queue.
    typedef struct packed {
        logic [1:0]       count;
        t_result [2:0]    slot;
    } t_bundle;

endpackage

FILE: design/csvd_front.sv
// Front end: holds decoder state, classifies each byte and builds its result bundle.
module csvd_front import csvd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wen,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_push,
    output t_bundle    o_bundle
);

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_BSL  = 2'd1;
    localparam logic [1:0] PH_X    = 2'd2;
    localparam logic [1:0] PH_HI   = 2'd3;

    // Bit 4 set marks a byte that is not an upper-case hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b0, 4'(b - 8'h30)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b0, 4'(b - 8'h37)};
        end
        return v;
    endfunction

    logic [7:0] r_delim;
    logic       r_quotes, n_quotes;
    logic [1:0] r_phase, n_phase;
    logic [3:0] r_nibble, n_nibble;
    logic       r_skip, n_skip;

    logic       ok;
    logic [1:0] cnt;
    logic [4:0] hv;
    t_result    slots [3];

    always_comb begin
        n_quotes = r_quotes;
        n_phase  = r_phase;
        n_nibble = r_nibble;
        n_skip   = r_skip;
        ok       = 1'b1;
        cnt      = 2'd0;
        hv       = hex_value(i_byte);
        for (int k = 0; k < 3; k++) begin
            slots[k] = '0;
        end

        if (r_skip) begin
            // drop bytes until the record's last one
            if (i_last) begin
                n_quotes = 1'b0;
                n_phase  = PH_NONE;
                n_nibble = 4'd0;
                n_skip   = 1'b0;
            end
        end else begin
            if (i_byte == QUOTE_BYTE) begin
                n_quotes = ~r_quotes;
            end else if (!r_quotes && i_byte == r_delim) begin
                if (r_phase == PH_X || r_phase == PH_HI) begin
                    ok = 1'b0;
                end else begin
                    if (r_phase == PH_BSL) begin
                        slots[cnt] = '{kind: KIND_DATA, value: BACKSLASH_BYTE};
                        cnt = cnt + 2'd1;
                    end
                    n_phase  = PH_NONE;
                    n_nibble = 4'd0;
                    slots[cnt] = '{kind: KIND_FIELD_END, value: 8'd0};
                    cnt = cnt + 2'd1;
                end
            end else begin
                case (r_phase)
                    PH_NONE: begin
                        if (i_byte == BACKSLASH_BYTE) begin
                            n_phase = PH_BSL;
                        end else begin
                            slots[cnt] = '{kind: KIND_DATA, value: i_byte};
                            cnt = cnt + 2'd1;
                        end
                    end
                    PH_BSL: begin
                        if (i_byte == BACKSLASH_BYTE) begin
                            slots[cnt] = '{kind: KIND_DATA, value: BACKSLASH_BYTE};
                            cnt = cnt + 2'd1;
                            n_phase = PH_NONE;
                        end else if (i_byte == X_BYTE) begin
                            n_phase = PH_X;
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    PH_X: begin
                        if (hv[4]) begin
                            ok = 1'b0;
                        end else begin
                            n_nibble = hv[3:0];
                            n_phase  = PH_HI;
                        end
                    end
                    default: begin
                        if (hv[4]) begin
                            ok = 1'b0;
                        end else begin
                            slots[cnt] = '{kind: KIND_DATA, value: {r_nibble, hv[3:0]}};
                            cnt = cnt + 2'd1;
                            n_phase  = PH_NONE;
                            n_nibble = 4'd0;
                        end
                    end
                endcase
            end

            // close the final field on the record's last byte
            if (ok && i_last) begin
                if (n_phase == PH_X || n_phase == PH_HI) begin
                    ok = 1'b0;
                end else begin
                    if (n_phase == PH_BSL) begin
                        slots[cnt] = '{kind: KIND_DATA, value: BACKSLASH_BYTE};
                        cnt = cnt + 2'd1;
                    end
                    slots[cnt] = '{kind: KIND_RECORD_END, value: 8'd0};
                    cnt = cnt + 2'd1;
                end
            end

            if (!ok) begin
                slots[cnt] = '{kind: KIND_ERROR, value: 8'd0};
                cnt = cnt + 2'd1;
                n_skip = ~i_last;
            end
            if (!ok || i_last) begin
                n_quotes = 1'b0;
                n_phase  = PH_NONE;
                n_nibble = 4'd0;
            end
        end
    end

    assign o_push         = i_accept && (cnt != 2'd0);
    assign o_bundle.count = cnt;
    assign o_bundle.slot  = {slots[2], slots[1], slots[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim  <= DELIM_RESET;
            r_quotes <= 1'b0;
            r_phase  <= PH_NONE;
            r_nibble <= 4'd0;
            r_skip   <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_delim <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_quotes <= n_quotes;
                r_phase  <= n_phase;
                r_nibble <= n_nibble;
                r_skip   <= n_skip;
            end
        end
    end

endmodule

FILE: design/csvd_fifo.sv
// Bundle queue between the front end and the output serializer.
module csvd_fifo import csvd_pkg::*; #(
    parameter int DEPTH = CSVD_FIFO_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    input  logic    i_pop,
    output t_bundle o_head,
    output logic    o_empty,
    output logic    o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_bundle          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_FULL);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: design/csvd_back.sv
// Back end: walks the head bundle one result at a time into the output register.
module csvd_back import csvd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_bundle    i_head,
    input  logic       i_empty,
    output logic       o_pop,
    input  logic       i_tready,
    output logic       o_tvalid,
    output logic [1:0] o_kind,
    output logic [7:0] o_value
);

    logic [1:0] r_slot;
    logic       r_valid;
    logic [1:0] r_kind;
    logic [7:0] r_value;
    logic       load;
    logic       last_slot;

    assign load      = !i_empty && (!r_valid || i_tready);
    assign last_slot = ((r_slot + 2'd1) == i_head.count);
    assign o_pop     = load && last_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_slot  <= last_slot ? 2'd0 : r_slot + 2'd1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= i_head.slot[r_slot].kind;
            r_value <= i_head.slot[r_slot].value;
        end
    end

    assign o_tvalid = r_valid;
    assign o_kind   = r_kind;
    assign o_value  = r_value;

endmodule

FILE: design/csv_record_decoder.sv
// Top level of the CSV record decoder: front end, bundle queue and output serializer.
// Accepts one record byte per cycle whenever the bundle queue has room; a byte turns
// into zero to three results (data byte, field end, record end, error), and results
// leave through the output register at one per cycle while the consumer is ready, so
// with a ready consumer the sustained rate is one byte per cycle for plain content.
// A byte's results are written into the bundle queue as the byte is taken and then
// move into the output register. Quotes toggle quoting and are dropped, the delimiter
// outside quotes ends a field, backslash-backslash and backslash-x-HH are decoded,
// and a bad or unfinished escape reports an error and skips the rest of the record,
// which the consumer discards.
module csv_record_decoder import csvd_pkg::*; #(
    parameter int FIFO_DEPTH = CSVD_FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wen,
    input  logic [7:0] i_cfg_wdata,    // delimiter
    input  logic       i_tvalid,
    output logic       o_tready,
    input  logic [7:0] i_tdata,        // [7:0] data_byte
    input  logic       i_tlast,        // last_of_record
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,        // [7:0] value
    output logic [1:0] o_tuser         // [1:0] kind
);

    logic    w_accept;
    logic    w_push;
    t_bundle w_bundle;
    t_bundle w_head;
    logic    w_pop;
    logic    w_empty;
    logic    w_full;

    assign o_tready = !w_full;
    assign w_accept = i_tvalid && o_tready;

    csvd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_byte      (i_tdata),
        .i_last      (i_tlast),
        .o_push      (w_push),
        .o_bundle    (w_bundle)
    );

    csvd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_bundle (w_bundle),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_empty  (w_empty),
        .o_full   (w_full)
    );

    csvd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .i_tready (i_tready),
        .o_tvalid (o_tvalid),
        .o_kind   (o_tuser),
        .o_value  (o_tdata)
    );

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid && (o_tuser != KIND_DATA) |-> (o_tdata == 8'd0))
        else $error("non-data result carries a nonzero value");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("bundle queue popped while empty");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_tvalid)
        else $error("output valid right after reset");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the CSV record decoder stream interface.
`timescale 1ns / 100ps

module testbench;
    import csvd_pkg::*;

    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_F = 8'h46;
    localparam logic [7:0] CHAR_Q = 8'h71;
    localparam logic [7:0] CHAR_Z = 8'h7A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [4:0] NOT_HEX = 5'd16;
    localparam int IDLE_SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES = 24;
    localparam int MAX_PRINTED = 40;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_AFTER_BSLASH,
        ESC_HEX_HIGH,
        ESC_HEX_LOW
    } t_esc_state;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wen;
    logic [7:0] i_cfg_wdata;
    logic       i_tvalid;
    logic       o_tready;
    logic [7:0] i_tdata;
    logic       i_tlast;
    logic       o_tvalid;
    logic       i_tready;
    logic [7:0] o_tdata;
    logic [1:0] o_tuser;

    // Decoder model state
    logic [7:0] delimiter    = DELIM_RESET;
    logic       in_quotes    = 1'b0;
    t_esc_state esc_state    = ESC_IDLE;
    logic [3:0] high_nibble  = 4'd0;
    logic       skip_rest    = 1'b0;

    t_result pending_tokens[$];
    int      error_count     = 0;
    int      accepted_count  = 0;
    bit      src_idle_en     = 1'b1;
    bit      sink_idle_en    = 1'b1;
    int      long_hold_req   = 0;

    csv_record_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tvalid    (i_tvalid),
        .o_tready    (o_tready),
        .i_tdata     (i_tdata),
        .i_tlast     (i_tlast),
        .o_tvalid    (o_tvalid),
        .i_tready    (i_tready),
        .o_tdata     (o_tdata),
        .o_tuser     (o_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        // cap the log; later mismatches are still counted
        if (error_count <= MAX_PRINTED) $display("%0t ERROR: %s", $time, msg);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic void push_token(logic [1:0] kind, logic [7:0] value);
        t_result tok;
        tok.kind  = kind;
        tok.value = value;
        pending_tokens.insert(pending_tokens.size(), tok);
    endfunction

    function automatic logic [4:0] hex_value(logic [7:0] b);
        if (b >= CHAR_0 && b <= CHAR_9) return 5'(b - CHAR_0);
        if (b >= CHAR_A && b <= CHAR_F) return 5'(b - CHAR_A + 8'd10);
        return NOT_HEX;
    endfunction

    function automatic void clear_record();
        in_quotes   = 1'b0;
        esc_state   = ESC_IDLE;
        high_nibble = 4'd0;
        skip_rest   = 1'b0;
    endfunction

    // Close the current field; an unfinished hex escape is an error.
    function automatic logic close_field(logic [1:0] kind);
        if (esc_state == ESC_HEX_HIGH || esc_state == ESC_HEX_LOW) return 1'b0;
        if (esc_state == ESC_AFTER_BSLASH) push_token(KIND_DATA, BACKSLASH_BYTE);
        esc_state   = ESC_IDLE;
        high_nibble = 4'd0;
        push_token(kind, 8'h00);
        return 1'b1;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic last);
        logic       ok;
        logic [4:0] h;
        ok = 1'b1;
        h  = hex_value(b);
        if (skip_rest) begin
            if (last) clear_record();
            return;
        end
        if (b == QUOTE_BYTE) begin
            in_quotes = ~in_quotes;
        end else if (!in_quotes && b == delimiter) begin
            ok = close_field(KIND_FIELD_END);
        end else begin
            case (esc_state)
                ESC_IDLE: begin
                    if (b == BACKSLASH_BYTE) esc_state = ESC_AFTER_BSLASH;
                    else push_token(KIND_DATA, b);
                end
                ESC_AFTER_BSLASH: begin
                    if (b == BACKSLASH_BYTE) begin
                        push_token(KIND_DATA, BACKSLASH_BYTE);
                        esc_state = ESC_IDLE;
                    end else if (b == X_BYTE) begin
                        esc_state = ESC_HEX_HIGH;
                    end else begin
                        ok = 1'b0;
                    end
                end
                ESC_HEX_HIGH: begin
                    if (h[4]) begin
                        ok = 1'b0;
                    end else begin
                        high_nibble = h[3:0];
                        esc_state   = ESC_HEX_LOW;
                    end
                end
                default: begin
                    if (h[4]) begin
                        ok = 1'b0;
                    end else begin
                        push_token(KIND_DATA, {high_nibble, h[3:0]});
                        esc_state   = ESC_IDLE;
                        high_nibble = 4'd0;
                    end
                end
            endcase
        end
        if (ok && last) ok = close_field(KIND_RECORD_END);
        if (!ok) begin
            push_token(KIND_ERROR, 8'h00);
            clear_record();
            if (!last) skip_rest = 1'b1;
        end else if (last) begin
            clear_record();
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = src_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            i_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_tvalid <= 1'b1;
        i_tdata  <= b;
        i_tlast  <= last;
        do @(posedge i_clk); while (o_tready !== 1'b1);
        if (!skip_rest) accepted_count++;
        decode_byte(b, last);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    // Drop valid, let every expected token drain, then let the pipeline settle.
    task automatic wait_idle();
        i_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_delimiter(input logic [7:0] d);
        wait_idle();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        delimiter    = d;
    endtask

    function automatic logic [7:0] plain_byte(bit high);
        logic [7:0] b;
        do begin
            b = high ? 8'($urandom_range(128, 255)) : 8'($urandom_range(32, 126));
        end while (b == QUOTE_BYTE || b == BACKSLASH_BYTE || b == delimiter);
        return b;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        return (n < 4'd10) ? CHAR_0 + 8'(n) : CHAR_A + 8'(n) - 8'd10;
    endfunction

    // Mostly well-formed records with random content, some noise and broken escapes.
    task automatic send_random_record();
        logic [7:0] rec[$];
        int nfields;
        int ntok;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 10)) rec.insert(rec.size(), 8'($urandom_range(1, 255)));
        end else begin
            nfields = $urandom_range(1, 4);
            for (int f = 0; f < nfields; f++) begin
                if (f > 0) rec.insert(rec.size(), delimiter);
                ntok = $urandom_range(0, 4);
                for (int t = 0; t < ntok; t++) begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7: rec.insert(rec.size(), plain_byte(1'b0));
                        8, 9, 10: begin
                            rec.insert(rec.size(), BACKSLASH_BYTE);
                            rec.insert(rec.size(), BACKSLASH_BYTE);
                        end
                        11, 12, 13, 14: begin
                            rec.insert(rec.size(), BACKSLASH_BYTE);
                            rec.insert(rec.size(), X_BYTE);
                            rec.insert(rec.size(), hex_char(4'($urandom_range(0, 15))));
                            rec.insert(rec.size(), hex_char(4'($urandom_range(0, 15))));
                        end
                        15, 16, 17: begin
                            rec.insert(rec.size(), QUOTE_BYTE);
                            repeat ($urandom_range(0, 3))
                                rec.insert(rec.size(),
                                           $urandom_range(0, 1) ? delimiter
                                                                : plain_byte(1'b0));
                            rec.insert(rec.size(), QUOTE_BYTE);
                        end
                        18: rec.insert(rec.size(), plain_byte(1'b1));
                        default: begin
                            rec.insert(rec.size(), BACKSLASH_BYTE);
                            if ($urandom_range(0, 1)) begin
                                rec.insert(rec.size(), 8'($urandom_range(1, 255)));
                            end else begin
                                rec.insert(rec.size(), X_BYTE);
                                repeat ($urandom_range(0, 2))
                                    rec.insert(rec.size(), 8'($urandom_range(1, 255)));
                            end
                        end
                    endcase
                end
                // leave a lone backslash at the end of the field now and then
                if ($urandom_range(0, 7) == 0) rec.insert(rec.size(), BACKSLASH_BYTE);
            end
        end
        if (rec.size() == 0) rec.insert(rec.size(), plain_byte(1'b0));
        foreach (rec[i]) send_byte(rec[i], i == rec.size() - 1);
    endtask

    task automatic test_escapes();
        // quoted delimiter, backslash pair, hex escape, lone backslash at record end
        send_text("\",\"\\\\\\xFF,\\");
        // hex zero, then a lone backslash closed by a delimiter on the last byte
        send_text("\\x00\\,");
    endtask

    task automatic test_bad_escapes();
        send_text("\\qzz");     // bad escape mid record, rest skipped
        send_text("\\xa");      // lower-case hex digit on the last byte
        send_text("\"\\x");     // unclosed quote and unfinished hex escape
    endtask

    task automatic test_delimiter_settings();
        set_delimiter(QUOTE_BYTE);
        send_text("\",");
        set_delimiter(8'hFF);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b1);
        set_delimiter(8'h01);
        send_byte(8'h01, 1'b1);
    endtask

    task automatic run_random_phase(input logic [7:0] d, input bit idle);
        int start;
        set_delimiter(d);
        src_idle_en  = idle;
        sink_idle_en = idle;
        start = accepted_count;
        while (accepted_count - start < PHASE_BYTES) send_random_record();
    endtask

    task automatic test_random();
        logic [7:0] d;
        do d = 8'($urandom_range(1, 255)); while (d == QUOTE_BYTE || d == BACKSLASH_BYTE);
        run_random_phase(DELIM_RESET, 1'b0);
        run_random_phase(CHAR_TAB, 1'b1);
        run_random_phase(d, 1'b1);
        run_random_phase(8'hFF, 1'b1);
        run_random_phase(8'h01, 1'b1);
    endtask

    task automatic test_backpressure();
        int start;
        set_delimiter(DELIM_RESET);
        src_idle_en   = 1'b0;
        sink_idle_en  = 1'b0;
        long_hold_req = 150;
        start = accepted_count;
        while (accepted_count - start < 30) send_random_record();
        wait_idle();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // Result side: check each transaction, then pick the next ready value.
    initial begin
        int stall_left;
        t_result want;
        stall_left = 0;
        i_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_tvalid === 1'b1 && i_tready === 1'b1) begin
                if (pending_tokens.size() == 0) begin
                    report_mismatch($sformatf("unexpected token kind %0d value %02h",
                                              o_tuser, o_tdata));
                end else begin
                    want = pending_tokens.pop_front();
                    if (o_tuser !== want.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  o_tuser, want.kind));
                    if (o_tdata !== want.value)
                        report_mismatch($sformatf("value %02h, expected %02h",
                                                  o_tdata, want.value));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_tready <= 1'b0;
            end else if (long_hold_req > 0) begin
                stall_left    = long_hold_req - 1;
                long_hold_req = 0;
                i_tready <= 1'b0;
            end else begin
                i_tready <= 1'b1;
                if (sink_idle_en) stall_left = pick_gap();
            end
        end
    end

    initial begin
        int drain_cycles;
        i_rst_n     <= 1'b0;
        i_cfg_wen   <= 1'b0;
        i_cfg_wdata <= 8'h00;
        i_tvalid    <= 1'b0;
        i_tdata     <= 8'h00;
        i_tlast     <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_escapes();
        test_bad_escapes();
        test_delimiter_settings();
        test_random();
        test_backpressure();

        i_tvalid <= 1'b0;
        drain_cycles = 0;
        while (pending_tokens.size() != 0 && drain_cycles < 5000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (IDLE_SETTLE_CYCLES) @(posedge i_clk);
        if (pending_tokens.size() != 0)
            report_mismatch($sformatf("%0d tokens never arrived", pending_tokens.size()));
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
